// ===== design/nss_pkg.sv =====
package nss_pkg;

    localparam int MAX_SRC_W = 256;
    localparam int MAX_SRC_H = 256;
    localparam int MAX_DST_W = 128;
    localparam int MAX_DST_H = 128;

    localparam int STORE_DEPTH = MAX_SRC_W * MAX_SRC_H;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int PIX_W       = 24;
    localparam int QUOT_W      = 8;
    localparam int DIVISOR_W   = 8;
    localparam int DIVIDEND_W  = 15;
    localparam int REM_W       = DIVIDEND_W - QUOT_W;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_FETCH = 1'b1;

    localparam logic [1:0] REG_SRC_W = 2'd0;
    localparam logic [1:0] REG_SRC_H = 2'd1;
    localparam logic [1:0] REG_DST_W = 2'd2;
    localparam logic [1:0] REG_DST_H = 2'd3;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_RANGE = 1'b1;

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [QUOT_W-1:0] quotient;
    } div_rsp_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [PIX_W-1:0]  data;
    } store_wr_t;

    // zero acts as one, anything past the maximum acts as the maximum
    function automatic logic [8:0] eff_src(input logic [8:0] v, input logic [8:0] vmax);
        logic [8:0] r;
        begin
            r = v;
            if (v == 9'd0)
            begin
                r = 9'd1;
            end
            else if (v > vmax)
            begin
                r = vmax;
            end
            return r;
        end
    endfunction

    function automatic logic [7:0] eff_dst(input logic [7:0] v, input logic [7:0] vmax);
        logic [7:0] r;
        begin
            r = v;
            if (v == 8'd0)
            begin
                r = 8'd1;
            end
            else if (v > vmax)
            begin
                r = vmax;
            end
            return r;
        end
    endfunction

    // truncating pack of r,g,b into 5-6-5
    function automatic logic [15:0] pack565(input logic [PIX_W-1:0] p);
        return {p[23:19], p[15:10], p[7:3]};
    endfunction

endpackage

// ===== design/nss_div.sv =====
module nss_div (
    input  logic              clk,
    input  logic              rst_n,
    input  nss_pkg::div_req_t req,
    output nss_pkg::div_rsp_t rsp
);

    logic [nss_pkg::REM_W-1:0]     rem_reg, rem_next;
    logic [nss_pkg::QUOT_W-1:0]    bits_reg, bits_next;
    logic [nss_pkg::DIVISOR_W-1:0] dvs_reg, dvs_next;
    logic [2:0]                    count_reg, count_next;
    logic                          run_reg, run_next;
    logic                          done_reg, done_next;

    logic [nss_pkg::REM_W:0]       trial;
    logic [nss_pkg::REM_W:0]       diff;
    logic                          ge;

    // one quotient bit a cycle; the quotient shifts in where dividend bits leave
    assign trial = {rem_reg, bits_reg[nss_pkg::QUOT_W-1]};
    assign ge    = (trial >= dvs_reg);
    assign diff  = trial - dvs_reg;

    always_comb
    begin
        rem_next   = rem_reg;
        bits_next  = bits_reg;
        dvs_next   = dvs_reg;
        count_next = count_reg;
        run_next   = run_reg;
        done_next  = 1'b0;
        if (req.start)
        begin
            // quotient fits in 8 bits, so the top bits are already below the divisor
            rem_next   = req.dividend[nss_pkg::DIVIDEND_W-1:nss_pkg::QUOT_W];
            bits_next  = req.dividend[nss_pkg::QUOT_W-1:0];
            dvs_next   = req.divisor;
            count_next = 3'd0;
            run_next   = 1'b1;
        end
        else if (run_reg)
        begin
            rem_next   = ge ? diff[nss_pkg::REM_W-1:0] : trial[nss_pkg::REM_W-1:0];
            bits_next  = {bits_reg[nss_pkg::QUOT_W-2:0], ge};
            count_next = count_reg + 3'd1;
            if (count_reg == 3'd7)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 3'd0;
            run_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            run_reg   <= run_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        bits_reg <= bits_next;
        dvs_reg  <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = bits_reg;

endmodule

// ===== design/nss_store.sv =====
module nss_store (
    input  logic                       clk,
    input  nss_pkg::store_wr_t         wr,
    input  logic                       rd_en,
    input  logic [nss_pkg::ADDR_W-1:0] rd_addr,
    output logic [nss_pkg::PIX_W-1:0]  rd_data
);

    logic [nss_pkg::PIX_W-1:0] mem [0:nss_pkg::STORE_DEPTH-1];
    logic [nss_pkg::PIX_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/nearest_scale_rgb565.sv =====
// nearest-neighbour scaler: 24-bit source frame in, RGB565 pixels out
// command channel: an item is taken at a clock edge with start high and busy low.
//   opcode load: red/green/blue go to the next source entry in raster order;
//   frame_start puts the pixel at entry 0. loads past src_width*src_height are
//   dropped. a load gives no result and never raises busy.
//   opcode fetch: dest_col/dest_row are mapped to the source pixel
//   floor(row*sh/dh), floor(col*sw/dw) and returned packed as RGB565.
// result channel: result_valid is high for one cycle with pixel_565, col_echo,
//   row_echo and status; the receiver cannot hold it off, so nothing stalls.
// a fetch outside the destination size answers in the next cycle with status 1.
// an in-range fetch raises result_valid after two passes of the shared restoring
//   divider (row, then column) and the registered store read, with busy high
//   throughout, so no new item is taken until the fetch has answered.
// configuration: wr_en/wr_index/wr_data write one of src_width, src_height,
//   dst_width, dst_height per cycle; write only while the block is idle.
// reset (rst_n low, asynchronous) clears the write pointer and sets the sizes
//   to 64, 64, 64, 32; source store contents are undefined until loaded.
module nearest_scale_rgb565 (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        opcode,
    input  logic        frame_start,
    input  logic [7:0]  red,
    input  logic [7:0]  green,
    input  logic [7:0]  blue,
    input  logic [6:0]  dest_col,
    input  logic [6:0]  dest_row,
    input  logic        wr_en,
    input  logic [1:0]  wr_index,
    input  logic [8:0]  wr_data,
    output logic        result_valid,
    output logic [15:0] pixel_565,
    output logic [6:0]  col_echo,
    output logic [6:0]  row_echo,
    output logic        status
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV_Y,
        ST_DIV_X,
        ST_PACK
    } state_t;

    state_t      state_reg, state_next;
    logic [16:0] wp_reg, wp_next;
    logic [8:0]  src_w_reg, src_w_next;
    logic [8:0]  src_h_reg, src_h_next;
    logic [7:0]  dst_w_reg, dst_w_next;
    logic [7:0]  dst_h_reg, dst_h_next;
    logic [6:0]  col_reg, col_next;
    logic [6:0]  row_reg, row_next;
    logic [7:0]  sy_reg, sy_next;
    logic        valid_reg, valid_next;
    logic [15:0] pixel_reg, pixel_next;
    logic [6:0]  col_echo_reg, col_echo_next;
    logic [6:0]  row_echo_reg, row_echo_next;
    logic        status_reg, status_next;

    logic [8:0]  sw;
    logic [8:0]  sh;
    logic [7:0]  dw;
    logic [7:0]  dh;
    logic [17:0] area;
    logic [16:0] wp_eff;
    logic [8:0]  mul_a;
    logic [7:0]  mul_b;
    logic [16:0] prod;
    logic        accept;

    nss_pkg::div_req_t  div_req;
    nss_pkg::div_rsp_t  div_rsp;
    nss_pkg::store_wr_t store_wr;
    logic                       rd_en;
    logic [nss_pkg::ADDR_W-1:0] rd_addr;
    logic [nss_pkg::PIX_W-1:0]  rd_data;

    nss_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    nss_store u_store (
        .clk     (clk),
        .wr      (store_wr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign sw = nss_pkg::eff_src(src_w_reg, 9'(nss_pkg::MAX_SRC_W));
    assign sh = nss_pkg::eff_src(src_h_reg, 9'(nss_pkg::MAX_SRC_H));
    assign dw = nss_pkg::eff_dst(dst_w_reg, 8'(nss_pkg::MAX_DST_W));
    assign dh = nss_pkg::eff_dst(dst_h_reg, 8'(nss_pkg::MAX_DST_H));

    assign area   = sw * sh;
    assign wp_eff = frame_start ? 17'd0 : wp_reg;
    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    // shared fetch multiplier: row*sh, then col*sw, then sy*sw for the address
    always_comb
    begin
        case (state_reg)
            ST_IDLE:
            begin
                mul_a = sh;
                mul_b = {1'b0, dest_row};
            end
            ST_DIV_Y:
            begin
                mul_a = sw;
                mul_b = {1'b0, col_reg};
            end
            default:
            begin
                mul_a = sw;
                mul_b = sy_reg;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    always_comb
    begin
        state_next    = state_reg;
        wp_next       = wp_reg;
        src_w_next    = src_w_reg;
        src_h_next    = src_h_reg;
        dst_w_next    = dst_w_reg;
        dst_h_next    = dst_h_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        sy_next       = sy_reg;
        valid_next    = 1'b0;
        pixel_next    = pixel_reg;
        col_echo_next = col_echo_reg;
        row_echo_next = row_echo_reg;
        status_next   = status_reg;
        div_req       = '0;
        store_wr      = '0;
        rd_en         = 1'b0;
        rd_addr       = prod[nss_pkg::ADDR_W-1:0]
                        + {{(nss_pkg::ADDR_W-8){1'b0}}, div_rsp.quotient};

        if (wr_en)
        begin
            case (wr_index)
                nss_pkg::REG_SRC_W: src_w_next = wr_data;
                nss_pkg::REG_SRC_H: src_h_next = wr_data;
                nss_pkg::REG_DST_W: dst_w_next = wr_data[7:0];
                nss_pkg::REG_DST_H: dst_h_next = wr_data[7:0];
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (opcode == nss_pkg::OP_LOAD)
                    begin
                        wp_next = wp_eff;
                        if ({1'b0, wp_eff} < area)
                        begin
                            store_wr.en   = 1'b1;
                            store_wr.addr = wp_eff[nss_pkg::ADDR_W-1:0];
                            store_wr.data = {red, green, blue};
                            wp_next       = wp_eff + 17'd1;
                        end
                    end
                    else
                    begin
                        col_next = dest_col;
                        row_next = dest_row;
                        if (({1'b0, dest_col} >= dw) || ({1'b0, dest_row} >= dh))
                        begin
                            valid_next    = 1'b1;
                            pixel_next    = 16'd0;
                            col_echo_next = dest_col;
                            row_echo_next = dest_row;
                            status_next   = nss_pkg::STATUS_RANGE;
                        end
                        else
                        begin
                            div_req.start    = 1'b1;
                            div_req.dividend = prod[nss_pkg::DIVIDEND_W-1:0];
                            div_req.divisor  = dh;
                            state_next       = ST_DIV_Y;
                        end
                    end
                end
            end
            ST_DIV_Y:
            begin
                if (div_rsp.done)
                begin
                    sy_next          = div_rsp.quotient;
                    div_req.start    = 1'b1;
                    div_req.dividend = prod[nss_pkg::DIVIDEND_W-1:0];
                    div_req.divisor  = dw;
                    state_next       = ST_DIV_X;
                end
            end
            ST_DIV_X:
            begin
                // address sy*sw + sx goes straight to the store read port
                if (div_rsp.done)
                begin
                    rd_en      = 1'b1;
                    state_next = ST_PACK;
                end
            end
            ST_PACK:
            begin
                valid_next    = 1'b1;
                pixel_next    = nss_pkg::pack565(rd_data);
                col_echo_next = col_reg;
                row_echo_next = row_reg;
                status_next   = nss_pkg::STATUS_OK;
                state_next    = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            wp_reg    <= 17'd0;
            src_w_reg <= 9'd64;
            src_h_reg <= 9'd64;
            dst_w_reg <= 8'd64;
            dst_h_reg <= 8'd32;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            wp_reg    <= wp_next;
            src_w_reg <= src_w_next;
            src_h_reg <= src_h_next;
            dst_w_reg <= dst_w_next;
            dst_h_reg <= dst_h_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        col_reg      <= col_next;
        row_reg      <= row_next;
        sy_reg       <= sy_next;
        pixel_reg    <= pixel_next;
        col_echo_reg <= col_echo_next;
        row_echo_reg <= row_echo_next;
        status_reg   <= status_next;
    end

    assign result_valid = valid_reg;
    assign pixel_565    = pixel_reg;
    assign col_echo     = col_echo_reg;
    assign row_echo     = row_echo_reg;
    assign status       = status_reg;

endmodule

// ===== verif/rgb565_fetch_checker.sv =====
module rgb565_fetch_checker
    import nss_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic        opcode,
    input  logic        frame_start,
    input  logic [7:0]  red,
    input  logic [7:0]  green,
    input  logic [7:0]  blue,
    input  logic [6:0]  dest_col,
    input  logic [6:0]  dest_row,
    input  logic        wr_en,
    input  logic [1:0]  wr_index,
    input  logic [8:0]  wr_data,
    input  logic        result_valid,
    input  logic [15:0] pixel_565,
    input  logic [6:0]  col_echo,
    input  logic [6:0]  row_echo,
    input  logic        status,
    output int          mismatches,
    output int          pixels_due
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [15:0] pix;
        logic [6:0]  col;
        logic [6:0]  row;
        logic        st;
    } fetch_result_t;

    logic [23:0]   frame_copy [0:STORE_DEPTH-1];
    fetch_result_t pending_pixels [$];
    fetch_result_t oldest;
    int            load_ptr;
    int            fail_total;
    logic [8:0]    src_w_reg;
    logic [8:0]    src_h_reg;
    logic [7:0]    dst_w_reg;
    logic [7:0]    dst_h_reg;

    // zero behaves as one, anything over the limit as the limit
    function automatic int size_limit(input int v, input int vmax);
        if (v == 0)
        begin
            return 1;
        end
        return (v > vmax) ? vmax : v;
    endfunction

    function automatic fetch_result_t scaled_pixel(input logic [6:0] col, input logic [6:0] row);
        fetch_result_t r;
        int            sw;
        int            sh;
        int            dw;
        int            dh;
        int            sx;
        int            sy;
        logic [23:0]   p;
        sw = size_limit(int'(src_w_reg), MAX_SRC_W);
        sh = size_limit(int'(src_h_reg), MAX_SRC_H);
        dw = size_limit(int'(dst_w_reg), MAX_DST_W);
        dh = size_limit(int'(dst_h_reg), MAX_DST_H);
        r.col = col;
        r.row = row;
        r.pix = 16'h0000;
        r.st  = STATUS_RANGE;
        if (int'(col) < dw && int'(row) < dh)
        begin
            sy    = (int'(row) * sh) / dh;
            sx    = (int'(col) * sw) / dw;
            p     = frame_copy[sy * sw + sx];
            r.pix = {p[23:19], p[15:10], p[7:3]};
            r.st  = STATUS_OK;
        end
        return r;
    endfunction

    // four-state compare so an unknown output never passes
    function automatic int field_check(input string name, input logic [15:0] want,
                                       input logic [15:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_pixels.delete();
            load_ptr   = 0;
            fail_total = 0;
            src_w_reg  = 9'd64;
            src_h_reg  = 9'd64;
            dst_w_reg  = 8'd64;
            dst_h_reg  = 8'd32;
            mismatches <= 0;
            pixels_due <= 0;
        end
        else
        begin
            if (result_valid)
            begin
                if (pending_pixels.size() == 0)
                begin
                    $display("%0t: result with no fetch waiting, expected none, got %h %0d %0d %b",
                             $time, pixel_565, col_echo, row_echo, status);
                    fail_total++;
                end
                else
                begin
                    oldest = pending_pixels.pop_front();
                    fail_total += field_check("pixel_565", oldest.pix, pixel_565);
                    fail_total += field_check("col_echo", 16'(oldest.col), 16'(col_echo));
                    fail_total += field_check("row_echo", 16'(oldest.row), 16'(row_echo));
                    fail_total += field_check("status", 16'(oldest.st), 16'(status));
                end
            end
            if (wr_en)
            begin
                case (wr_index)
                    REG_SRC_W: src_w_reg = wr_data;
                    REG_SRC_H: src_h_reg = wr_data;
                    REG_DST_W: dst_w_reg = wr_data[7:0];
                    REG_DST_H: dst_h_reg = wr_data[7:0];
                    default: ;
                endcase
            end
            if (start && !busy)
            begin
                if (opcode == OP_LOAD)
                begin
                    if (frame_start)
                    begin
                        load_ptr = 0;
                    end
                    // loads past the frame are dropped and the pointer holds
                    if (load_ptr < size_limit(int'(src_w_reg), MAX_SRC_W) *
                                   size_limit(int'(src_h_reg), MAX_SRC_H))
                    begin
                        frame_copy[load_ptr] = {red, green, blue};
                        load_ptr++;
                    end
                end
                else
                begin
                    pending_pixels.push_back(scaled_pixel(dest_col, dest_row));
                end
            end
            mismatches <= fail_total;
            pixels_due <= pending_pixels.size();
        end
    end

endmodule

// ===== verif/tb_nearest_scale_rgb565.sv =====
module tb_nearest_scale_rgb565;

    import nss_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        opcode = OP_LOAD;
    logic        frame_start = 1'b0;
    logic [7:0]  red = 8'h00;
    logic [7:0]  green = 8'h00;
    logic [7:0]  blue = 8'h00;
    logic [6:0]  dest_col = 7'd0;
    logic [6:0]  dest_row = 7'd0;
    logic        wr_en = 1'b0;
    logic [1:0]  wr_index = REG_SRC_W;
    logic [8:0]  wr_data = 9'd0;
    logic        result_valid;
    logic [15:0] pixel_565;
    logic [6:0]  col_echo;
    logic [6:0]  row_echo;
    logic        status;
    int          mismatches;
    int          pixels_due;

    // what the stimulus knows of the block, so fetches only hit loaded entries
    int sw_reg = 64;
    int sh_reg = 64;
    int dw_reg = 64;
    int dh_reg = 32;
    int fill_ptr = 0;
    int filled = 0;
    int sent_items = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    nearest_scale_rgb565 dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .opcode(opcode),
        .frame_start(frame_start), .red(red), .green(green), .blue(blue),
        .dest_col(dest_col), .dest_row(dest_row), .wr_en(wr_en), .wr_index(wr_index),
        .wr_data(wr_data), .result_valid(result_valid), .pixel_565(pixel_565),
        .col_echo(col_echo), .row_echo(row_echo), .status(status)
    );

    rgb565_fetch_checker checker_i (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .opcode(opcode),
        .frame_start(frame_start), .red(red), .green(green), .blue(blue),
        .dest_col(dest_col), .dest_row(dest_row), .wr_en(wr_en), .wr_index(wr_index),
        .wr_data(wr_data), .result_valid(result_valid), .pixel_565(pixel_565),
        .col_echo(col_echo), .row_echo(row_echo), .status(status),
        .mismatches(mismatches), .pixels_due(pixels_due)
    );

    function automatic int size_limit(input int v, input int vmax);
        if (v == 0)
        begin
            return 1;
        end
        return (v > vmax) ? vmax : v;
    endfunction

    function automatic int frame_pixels();
        return size_limit(sw_reg, MAX_SRC_W) * size_limit(sh_reg, MAX_SRC_H);
    endfunction

    // out-of-range coordinates are always fine; in range they must land on a loaded entry
    function automatic bit fetch_ok(input int col, input int row);
        int sw;
        int sh;
        int dw;
        int dh;
        sw = size_limit(sw_reg, MAX_SRC_W);
        sh = size_limit(sh_reg, MAX_SRC_H);
        dw = size_limit(dw_reg, MAX_DST_W);
        dh = size_limit(dh_reg, MAX_DST_H);
        if (col >= dw || row >= dh)
        begin
            return 1'b1;
        end
        return ((row * sh / dh) * sw + col * sw / dw) < filled;
    endfunction

    task automatic send_item(input logic op, input logic fs, input logic [7:0] r,
                             input logic [7:0] g, input logic [7:0] b,
                             input logic [6:0] col, input logic [6:0] row);
        int idle_pct;
        int gap;
        idle_pct = (sent_items < 270) ? 28 : (sent_items < 540) ? 46 : 0;
        if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct)
        begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 24) : $urandom_range(1, 3);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start       <= 1'b1;
        opcode      <= op;
        frame_start <= fs;
        red         <= r;
        green       <= g;
        blue        <= b;
        dest_col    <= col;
        dest_row    <= row;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        sent_items++;
    endtask

    task automatic load_pixel(input logic fs, input logic [7:0] r, input logic [7:0] g,
                              input logic [7:0] b);
        send_item(OP_LOAD, fs, r, g, b, 7'($urandom_range(0, 127)),
                  7'($urandom_range(0, 127)));
        if (fs)
        begin
            fill_ptr = 0;
        end
        if (fill_ptr < frame_pixels())
        begin
            fill_ptr++;
            if (fill_ptr > filled)
            begin
                filled = fill_ptr;
            end
        end
    endtask

    task automatic load_random(input logic fs);
        load_pixel(fs, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)));
    endtask

    task automatic fetch_pixel(input int col, input int row);
        send_item(OP_FETCH, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  7'(col), 7'(row));
    endtask

    task automatic fetch_random();
        int col;
        int row;
        int tries;
        tries = 0;
        do
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                col = $urandom_range(0, 127);
                row = $urandom_range(0, 127);
            end
            else
            begin
                col = $urandom_range(0, size_limit(dw_reg, MAX_DST_W) - 1);
                row = $urandom_range(0, size_limit(dh_reg, MAX_DST_H) - 1);
            end
            tries++;
        end
        while (!fetch_ok(col, row) && tries < 16);
        // the first entry is always loaded by now
        if (!fetch_ok(col, row))
        begin
            col = 0;
            row = 0;
        end
        fetch_pixel(col, row);
    endtask

    // hold off until every fetch has answered and the last load has drained
    task automatic settle();
        start <= 1'b0;
        @(posedge clk);
        while (pixels_due != 0 || busy)
        begin
            @(posedge clk);
        end
        repeat (25) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [8:0] val);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= val;
        @(posedge clk);
    endtask

    task automatic set_sizes(input int sw, input int sh, input int dw, input int dh);
        settle();
        write_reg(REG_SRC_W, 9'(sw));
        write_reg(REG_SRC_H, 9'(sh));
        write_reg(REG_DST_W, 9'(dw));
        write_reg(REG_DST_H, 9'(dh));
        wr_en  <= 1'b0;
        sw_reg = sw;
        sh_reg = sh;
        dw_reg = dw;
        dh_reg = dh;
    endtask

    initial
    begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        int phase;
        int burst;
        int mix;
        phase = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // 2x2 source scaled to 5x3, so the mapping does not divide evenly
        set_sizes(2, 2, 5, 3);
        load_pixel(1'b1, 8'hFF, 8'hFF, 8'hFF);
        load_pixel(1'b0, 8'h00, 8'h00, 8'h00);
        load_pixel(1'b0, 8'hAA, 8'h55, 8'hF0);
        load_pixel(1'b0, 8'h0F, 8'hF3, 8'h0C);
        // frame is full, this one is dropped
        load_pixel(1'b0, 8'h12, 8'h34, 8'h56);
        fetch_pixel(0, 0);
        fetch_pixel(4, 2);
        fetch_pixel(2, 0);
        fetch_pixel(3, 1);
        fetch_pixel(0, 2);
        fetch_pixel(5, 0);
        fetch_pixel(0, 3);
        fetch_pixel(127, 127);
        fetch_pixel(127, 0);
        // restart the frame and overwrite the first two entries
        load_pixel(1'b1, 8'h07, 8'h03, 8'h07);
        fetch_pixel(0, 0);
        load_pixel(1'b0, 8'hF8, 8'hFC, 8'hF8);
        fetch_pixel(3, 1);

        while (sent_items < 820)
        begin
            case (phase % 8)
                0: set_sizes(64, 64, 64, 32);
                1: set_sizes(1, 1, 1, 1);
                2: set_sizes(256, 256, 128, 128);
                3: set_sizes(0, 0, 0, 0);
                4: set_sizes(511, $urandom_range(257, 511), 255, $urandom_range(129, 255));
                default: set_sizes($urandom_range(1, 16), $urandom_range(1, 16),
                                   $urandom_range(1, 24), $urandom_range(1, 24));
            endcase
            // large frames are only partly loaded, fetches keep to the loaded entries
            burst = (frame_pixels() < 300) ? frame_pixels() : 300;
            load_random(1'b1);
            for (int i = 1; i < burst; i++)
            begin
                load_random(1'b0);
            end
            mix = $urandom_range(40, 100);
            for (int i = 0; i < mix; i++)
            begin
                if ($urandom_range(0, 99) < 65)
                begin
                    fetch_random();
                end
                else
                begin
                    load_random($urandom_range(0, 11) == 0);
                end
            end
            phase++;
        end

        start <= 1'b0;
        @(posedge clk);
        while (pixels_due != 0)
        begin
            @(posedge clk);
        end
        repeat (30) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
